/* src/linear_probe_pointer_map_defines.svh */
// Assertion macros for the pointer map and its checker.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef LINEAR_PROBE_POINTER_MAP_DEFINES_SVH
`define LINEAR_PROBE_POINTER_MAP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LPMAP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LPMAP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lpmap_pkg.sv */
`default_nettype none

package lpmap_pkg;

  localparam int KEY_W      = 64;
  localparam int VAL_W      = 64;
  localparam int FUNC_W     = 2;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 11;
  localparam int LOAD_W     = 10;
  localparam int HASH_SHIFT = 16;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam logic [LOAD_W-1:0] MAX_LOAD_RESET = LOAD_W'(768);

  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_KEY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_VALUE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL       = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } lpmap_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  result_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entries_used;
  } lpmap_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lpmap_slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } lpmap_state_t;

endpackage

`default_nettype wire

/* src/lpmap_ram.sv */
`default_nettype none

module lpmap_ram #(
  parameter  int DEPTH = lpmap_pkg::CAPACITY_DEFAULT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire lpmap_pkg::lpmap_slot_t wr_data,
  input  wire logic [AW-1:0]         rd_addr,
  output      lpmap_pkg::lpmap_slot_t rd_data
);

  lpmap_pkg::lpmap_slot_t mem [DEPTH];
  lpmap_pkg::lpmap_slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/lpmap_ctrl.sv */
`default_nettype none

module lpmap_ctrl #(
  parameter  int CAPACITY = lpmap_pkg::CAPACITY_DEFAULT,
  localparam int AW       = $clog2(CAPACITY)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire lpmap_pkg::lpmap_in_t         in_data,
  input  wire logic [lpmap_pkg::LOAD_W-1:0] max_load,
  output      logic                         res_valid,
  output      lpmap_pkg::lpmap_out_t        res_data,
  input  wire logic                         res_take,
  output      logic                         mem_we,
  output      logic [AW-1:0]                mem_waddr,
  output      lpmap_pkg::lpmap_slot_t       mem_wdata,
  output      logic [AW-1:0]                mem_raddr,
  input  wire lpmap_pkg::lpmap_slot_t       mem_rdata
);

  localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int KW   = lpmap_pkg::KEY_W;
  localparam int VW   = lpmap_pkg::VAL_W;
  localparam int CW   = lpmap_pkg::CNT_W;
  localparam int BW   = $clog2(KW);

  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(CAPACITY);

  lpmap_pkg::lpmap_state_t state_r, state_nxt;

  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [AW-1:0]                 probe_r, probe_nxt;
  logic [lpmap_pkg::FUNC_W-1:0]  func_r, func_nxt;
  logic [KW-1:0]                 key_r, key_nxt;
  logic [VW-1:0]                 val_r, val_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [VW-1:0]                 res_value_r, res_value_nxt;
  logic [lpmap_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [AW-1:0]                 rem_r, rem_nxt;
  logic [KW-1:0]                 hsh_r, hsh_nxt;
  logic [BW-1:0]                 bit_r, bit_nxt;

  logic [KW-1:0] hash_w;
  logic [AW:0]   rem_ext;
  logic [AW:0]   rem_red;
  logic [AW-1:0] idx_inc;
  logic          is_lookup;
  logic          bad_key;
  logic          bad_val;
  logic          go_probe;
  logic          hit;
  logic          empty;
  logic          probe_last;
  logic          probe_end;
  logic          table_full;
  logic          clr_last;
  logic          hash_last;

  assign hash_w    = in_data.key ^ (in_data.key >> lpmap_pkg::HASH_SHIFT);
  assign rem_ext   = {rem_r, hsh_r[KW-1]};
  assign rem_red   = (rem_ext >= CAP_EXT) ? rem_ext - CAP_EXT : rem_ext;
  assign idx_inc   = (idx_r == LAST_IDX) ? '0 : idx_r + AW'(1);

  assign is_lookup = (in_data.func == lpmap_pkg::FUNC_GET) ||
                     (in_data.func == lpmap_pkg::FUNC_SET);
  assign bad_key   = in_data.key == '0;
  assign bad_val   = (in_data.func == lpmap_pkg::FUNC_SET) && (in_data.value == '0);
  assign go_probe  = is_lookup && !bad_key && !bad_val;

  assign hit        = mem_rdata.key == key_r;
  assign empty      = mem_rdata.key == '0;
  assign probe_last = probe_r == LAST_IDX;
  assign probe_end  = hit || empty || probe_last;
  assign table_full = count_r >= {1'b0, max_load};
  assign clr_last   = idx_r == LAST_IDX;
  assign hash_last  = bit_r == BW'(KW - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpmap_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = lpmap_pkg::ST_IDLE;
        end
      end
      lpmap_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!go_probe) begin
            state_nxt = lpmap_pkg::ST_DONE;
          end else if (POW2) begin
            state_nxt = lpmap_pkg::ST_PROBE;
          end else begin
            state_nxt = lpmap_pkg::ST_HASH;
          end
        end
      end
      lpmap_pkg::ST_HASH: begin
        if (hash_last) begin
          state_nxt = lpmap_pkg::ST_PROBE;
        end
      end
      lpmap_pkg::ST_PROBE: begin
        if (probe_end) begin
          state_nxt = lpmap_pkg::ST_DONE;
        end
      end
      lpmap_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = (func_r == lpmap_pkg::FUNC_CLEAR) ? lpmap_pkg::ST_CLEAR
                                                        : lpmap_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpmap_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    probe_nxt      = probe_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    rem_nxt        = rem_r;
    hsh_nxt        = hsh_r;
    bit_nxt        = bit_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = '0;
    unique case (state_r)
      lpmap_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
      end
      lpmap_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt      = in_data.func;
          key_nxt       = in_data.key;
          val_nxt       = in_data.value;
          probe_nxt     = '0;
          rem_nxt       = '0;
          hsh_nxt       = hash_w;
          bit_nxt       = '0;
          res_value_nxt = '0;
          idx_nxt       = POW2 ? hash_w[AW-1:0] : '0;
          if (is_lookup && bad_key) begin
            res_status_nxt = lpmap_pkg::STAT_ZERO_KEY;
          end else if (bad_val) begin
            res_status_nxt = lpmap_pkg::STAT_ZERO_VALUE;
          end else begin
            res_status_nxt = lpmap_pkg::STAT_OK;
          end
          if (in_data.func == lpmap_pkg::FUNC_CLEAR) begin
            count_nxt = '0;
            idx_nxt   = '0;
          end
        end
      end
      lpmap_pkg::ST_HASH: begin
        rem_nxt = rem_red[AW-1:0];
        hsh_nxt = hsh_r << 1;
        bit_nxt = bit_r + BW'(1);
        if (hash_last) begin
          idx_nxt = rem_red[AW-1:0];
        end
      end
      lpmap_pkg::ST_PROBE: begin
        if (!probe_end) begin
          idx_nxt   = idx_inc;
          probe_nxt = probe_r + AW'(1);
        end else if (func_r == lpmap_pkg::FUNC_GET) begin
          res_value_nxt = hit ? mem_rdata.value : '0;
        end else if (hit) begin
          res_value_nxt   = mem_rdata.value;
          mem_we          = 1'b1;
          mem_wdata.key   = key_r;
          mem_wdata.value = val_r;
        end else if (empty && !table_full) begin
          mem_we          = 1'b1;
          mem_wdata.key   = key_r;
          mem_wdata.value = val_r;
          count_nxt       = count_r + CW'(1);
        end else begin
          res_status_nxt = lpmap_pkg::STAT_FULL;
        end
      end
      lpmap_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpmap_pkg::ST_CLEAR;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r      <= probe_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    rem_r        <= rem_nxt;
    hsh_r        <= hsh_nxt;
    bit_r        <= bit_nxt;
  end

  assign mem_raddr             = idx_nxt;
  assign in_stall              = state_r != lpmap_pkg::ST_IDLE;
  assign res_valid             = state_r == lpmap_pkg::ST_DONE;
  assign res_data.result_value = res_value_r;
  assign res_data.status       = res_status_r;
  assign res_data.entries_used = count_r;

endmodule

`default_nettype wire

/* src/linear_probe_pointer_map.sv */
// Open-addressed key-to-value map with linear probing over one slot memory of CAPACITY
// entries (key and value per slot, zero key means empty). The home slot is
// (key ^ key >> 16) modulo CAPACITY; a probe reads one slot per cycle through the
// memory's single read port until it finds the key or an empty slot or has read
// every slot. Rejected items and func 3 skip the probe. When CAPACITY is not a
// power of two the home slot comes from a bit-serial remainder unit that runs ahead
// of every accepted get and set. A clear returns its result first and then sweeps
// the whole memory; the same sweep runs after reset. in_stall is high while an item
// or a sweep is in progress. The result sits in an output register, so the next
// item may transfer in while it waits.
`default_nettype none

module linear_probe_pointer_map #(
  parameter int CAPACITY = lpmap_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire lpmap_pkg::lpmap_in_t         in_data,
  input  wire logic                         cfg_we,
  input  wire logic [lpmap_pkg::LOAD_W-1:0] cfg_wdata,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      lpmap_pkg::lpmap_out_t        out_data
);

  localparam int AW = $clog2(CAPACITY);

  logic [lpmap_pkg::LOAD_W-1:0] max_load_r;
  logic                         out_valid_r, out_valid_nxt;
  lpmap_pkg::lpmap_out_t        out_data_r;

  logic                   res_valid;
  lpmap_pkg::lpmap_out_t  res_data;
  logic                   res_take;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  lpmap_pkg::lpmap_slot_t mem_wdata;
  logic [AW-1:0]          mem_raddr;
  lpmap_pkg::lpmap_slot_t mem_rdata;

  assign res_take      = !out_valid_r || !out_stall;
  assign out_valid_nxt = (res_valid && res_take) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_load_r  <= lpmap_pkg::MAX_LOAD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_load_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res_data;
    end
  end

  lpmap_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .max_load  (max_load_r),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lpmap_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* src/lpmap_checker.sv */
`default_nettype none

`include "linear_probe_pointer_map_defines.svh"

module lpmap_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire lpmap_pkg::lpmap_out_t out_data
);

  `LPMAP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `LPMAP_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")
  `LPMAP_ASSERT_IMP(a_reject_zero, out_valid && out_data.status != lpmap_pkg::STAT_OK, out_data.result_value == '0, "rejected item returned a value")
  `LPMAP_ASSERT_IMP(a_count_range, out_valid, !out_data.entries_used[lpmap_pkg::CNT_W-1], "entry count beyond load limit range")

endmodule

bind linear_probe_pointer_map lpmap_checker u_lpmap_checker (.*);

`default_nettype wire

/* sim/pointer_map_checker.sv */
module pointer_map_checker
  import lpmap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  lpmap_in_t  in_data,
  input  logic       cfg_we,
  input  logic [LOAD_W-1:0] cfg_wdata,
  input  logic       out_valid,
  input  logic       out_stall,
  input  lpmap_out_t out_data,
  output int         mismatches,
  output int         pending,
  output int         compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = CAPACITY_DEFAULT;

  logic [KEY_W-1:0]  slot_key [SLOTS];
  logic [VAL_W-1:0]  slot_val [SLOTS];
  logic [CNT_W-1:0]  fill;
  logic [LOAD_W-1:0] load_limit;
  lpmap_out_t        awaited_replies [$];
  lpmap_out_t        want;

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    fill = '0;
  endfunction

  function automatic lpmap_out_t map_access(input lpmap_in_t op);
    lpmap_out_t r;
    int idx;
    logic hit;
    r = '0;
    if (op.func == FUNC_CLEAR) begin
      wipe_table();
    end else if (op.func == FUNC_GET || op.func == FUNC_SET) begin
      if (op.key == '0) begin
        r.status = STAT_ZERO_KEY;
      end else if (op.func == FUNC_SET && op.value == '0) begin
        r.status = STAT_ZERO_VALUE;
      end else begin
        idx = int'((op.key ^ (op.key >> HASH_SHIFT)) % SLOTS);
        hit = 1'b0;
        for (int n = 0; n < SLOTS && !hit; n++) begin
          if (slot_key[idx] == op.key || slot_key[idx] == '0) hit = 1'b1;
          else idx = (idx + 1) % SLOTS;
        end
        if (op.func == FUNC_GET) begin
          if (hit && slot_key[idx] != '0) r.result_value = slot_val[idx];
        end else if (!hit) begin
          r.status = STAT_FULL;
        end else if (slot_key[idx] == op.key) begin
          r.result_value = slot_val[idx];
          slot_val[idx] = op.value;
        end else if (fill >= CNT_W'(load_limit)) begin
          r.status = STAT_FULL;
        end else begin
          slot_key[idx] = op.key;
          slot_val[idx] = op.value;
          fill = fill + 1'b1;
        end
      end
    end
    r.entries_used = fill;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_table();
      load_limit = MAX_LOAD_RESET;
      awaited_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing outstanding: %p", $time, out_data);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("result_value", want.result_value, out_data.result_value);
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("entries_used", 64'(want.entries_used), 64'(out_data.entries_used));
          compared++;
        end
      end
      if (cfg_we) load_limit = cfg_wdata;
      if (in_valid && !in_stall) awaited_replies.push_back(map_access(in_data));
    end
    pending = awaited_replies.size();
  end

endmodule

/* sim/tb_linear_probe_pointer_map.sv */
module tb_linear_probe_pointer_map;
  timeunit 1ns;
  timeprecision 1ps;

  import lpmap_pkg::*;

  localparam int SLOTS       = CAPACITY_DEFAULT;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int SETTLE      = SLOTS + 64;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_MAX    = 48;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  lpmap_in_t         in_data = '0;
  logic              cfg_we = 1'b0;
  logic [LOAD_W-1:0] cfg_wdata = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lpmap_out_t        out_data;

  int                mismatches;
  int                pending;
  int                compared;
  int                cycle_count = 0;
  int                items_sent = 0;
  bit                calm = 1'b0;
  bit                want_hold = 1'b0;
  logic [KEY_W-1:0]  key_pool [$];

  linear_probe_pointer_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pointer_map_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [KEY_W-1:0] make_key(input int home);
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    k[IDX_W-1:0] = IDX_W'(home) ^ k[HASH_SHIFT +: IDX_W];
    if (k == '0) k[KEY_W-1] = 1'b1;
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r >= 97) return '0;
    if (r < 78) k = make_key((SLOTS - 4 + $urandom_range(0, 5)) % SLOTS);
    else k = {$urandom, $urandom};
    if (key_pool.size() >= POOL_MAX) key_pool.delete($urandom_range(0, POOL_MAX - 1));
    if (k != '0) key_pool.push_back(k);
    return k;
  endfunction

  function automatic lpmap_in_t random_op();
    lpmap_in_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) it.func = FUNC_GET;
    else if (r < 93) it.func = FUNC_SET;
    else if (r < 96) it.func = FUNC_CLEAR;
    else it.func = FUNC_NOP;
    it.key = pick_key();
    r = $urandom_range(0, 99);
    if (r < 3) it.value = '0;
    else if (r < 5) it.value = '1;
    else it.value = {$urandom, $urandom};
    return it;
  endfunction

  task automatic send(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                      input logic [VAL_W-1:0] v);
    int gap;
    in_data <= '{func: f, key: k, value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_ops(input int count, input bit steady);
    lpmap_in_t it;
    for (int i = 0; i < count; i++) begin
      if (steady) calm = 1'b1;
      else if (i % 30 == 0) calm = ($urandom_range(0, 4) == 0);
      it = random_op();
      send(it.func, it.key, it.value);
    end
    calm = 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_load(input logic [LOAD_W-1:0] v);
    drain_results();
    // hold off until any clear sweep has finished
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    logic [KEY_W-1:0] ka, kb, kc, kd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    ka = make_key(SLOTS - 1);
    kb = make_key(SLOTS - 1);
    kc = make_key(SLOTS - 1);
    kd = make_key(SLOTS - 1);

    send(FUNC_GET, 64'd1, '0);
    send(FUNC_SET, 64'd1, '1);
    send(FUNC_GET, 64'd1, '0);
    send(FUNC_SET, 64'd1, 64'd5);
    send(FUNC_SET, '0, 64'd7);
    send(FUNC_GET, '0, '0);
    send(FUNC_SET, 64'd2, '0);
    send(FUNC_GET, 64'd2, '0);
    send(FUNC_NOP, '1, '1);
    send(FUNC_SET, '1, 64'd1);
    send(FUNC_GET, '1, '0);
    send(FUNC_SET, ka, 64'hA);
    send(FUNC_SET, kb, 64'hB);
    send(FUNC_SET, kc, 64'hC);
    send(FUNC_GET, kc, '0);
    send(FUNC_GET, kb, '0);
    send(FUNC_SET, kb, '1);
    send(FUNC_GET, kd, '0);
    send(FUNC_CLEAR, '1, '1);
    send(FUNC_GET, 64'd1, '0);
    send(FUNC_SET, 64'd1, 64'd9);
    random_ops(120, 1'b0);

    write_load(LOAD_W'(1));
    send(FUNC_CLEAR, '0, '0);
    send(FUNC_SET, ka, 64'd11);
    send(FUNC_SET, kb, 64'd12);
    send(FUNC_SET, ka, 64'd13);
    send(FUNC_GET, kb, '0);
    random_ops(120, 1'b0);

    write_load('1);
    random_ops(60, 1'b0);
    want_hold = 1'b1;
    random_ops(40, 1'b1);
    drain_results();
    random_ops(300, 1'b0);

    write_load(LOAD_W'(9));
    random_ops(200, 1'b0);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d get/set/clear/unused transfers under load limits 768, 1, 1023 and 9;",
             items_sent);
    $display("compared %0d results, %0d mismatches.", compared, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
